FILE: rtl/tcl_pkg.sv
`default_nettype none
package tcl_pkg;

  localparam int CJ_SEGS = 9;
  localparam int TC_SEGS = 16;

  typedef logic [3:0] seg_t;

  localparam logic [12:0] TEMP_MAX = 13'h1FFF;

  localparam logic [11:0] CJ_EDGE [CJ_SEGS+1] = '{
    12'd0, 12'd160, 12'd320, 12'd640, 12'd960, 12'd1280, 12'd1600, 12'd1920,
    12'd2560, 12'd4000
  };
  localparam logic [10:0] CJ_SPAN [CJ_SEGS] = '{
    11'd160, 11'd160, 11'd320, 11'd320, 11'd320, 11'd320, 11'd320, 11'd640,
    11'd1440
  };
  localparam logic [7:0] CJ_RISE [CJ_SEGS] = '{
    8'd25, 8'd26, 8'd51, 8'd52, 8'd52, 8'd53, 8'd53, 8'd106, 8'd238
  };
  localparam logic [8:0] CJ_BASE [CJ_SEGS] = '{
    9'd0, 9'd25, 9'd51, 9'd102, 9'd154, 9'd206, 9'd259, 9'd312, 9'd418
  };

  localparam logic [11:0] TC_EDGE [TC_SEGS+1] = '{
    12'h066, 12'h09A, 12'h0CE, 12'h103, 12'h138, 12'h1A2, 12'h20C, 12'h2DE,
    12'h3AC, 12'h478, 12'h548, 12'h61B, 12'h6F2, 12'h7C7, 12'h89F, 12'h978,
    12'hA52
  };
  localparam logic [7:0] TC_DIV [TC_SEGS] = '{
    8'h34, 8'h34, 8'h35, 8'h35, 8'h6A, 8'h6A, 8'hD2, 8'hCE, 8'hCD,
    8'hD0, 8'hD3, 8'hD7, 8'hD5, 8'hD8, 8'hD9, 8'hDA
  };
  localparam logic [5:0] TC_DT [TC_SEGS] = '{
    6'd10, 6'd10, 6'd10, 6'd10, 6'd20, 6'd20, 6'd40, 6'd40, 6'd40,
    6'd40, 6'd40, 6'd40, 6'd40, 6'd40, 6'd40, 6'd40
  };
  localparam logic [16:0] TC_T0DIV [TC_SEGS] = '{
    17'(20 * 52), 17'(30 * 52), 17'(40 * 53), 17'(50 * 53),
    17'(60 * 106), 17'(80 * 106), 17'(100 * 210), 17'(140 * 206),
    17'(180 * 205), 17'(220 * 208), 17'(260 * 211), 17'(300 * 215),
    17'(340 * 213), 17'(380 * 216), 17'(420 * 217), 17'(460 * 218)
  };

  typedef struct packed {
    logic        op;
    logic        oor;
    seg_t        seg;
    logic [10:0] off;
  } dec_t;

  typedef struct packed {
    logic       op;
    logic       oor;
    logic [8:0] base;
  } num_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/tcl_decode.sv
`default_nettype none
module tcl_decode (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               op,
  input  wire logic signed [15:0] raw_code,
  input  wire logic               down_stall,
  output logic                    up_stall,
  output logic                    valid,
  output tcl_pkg::dec_t           dec
);
  import tcl_pkg::*;

  logic        cj_oor;
  logic [11:0] cj_q;
  seg_t        cj_seg;
  logic        tc_oor;
  logic [11:0] tc_c;
  seg_t        tc_seg;
  dec_t        dec_next;

  always_comb begin
    cj_oor = (raw_code < -16'sd3) || (!raw_code[15] && (raw_code[14:2] > 13'd4000));
    cj_q   = raw_code[15] ? 12'd0 : raw_code[13:2];
    cj_seg = seg_t'(CJ_SEGS - 1);
    for (int i = CJ_SEGS - 2; i >= 0; i--) begin
      if (cj_q <= CJ_EDGE[i+1]) cj_seg = seg_t'(i);
    end

    tc_oor = (raw_code <= 16'sh0066) || (raw_code > 16'sh0A52);
    tc_c   = raw_code[11:0];
    tc_seg = seg_t'(TC_SEGS - 1);
    for (int i = TC_SEGS - 2; i >= 0; i--) begin
      if (tc_c <= TC_EDGE[i+1]) tc_seg = seg_t'(i);
    end

    dec_next.op = op;
    if (op) begin
      dec_next.oor = tc_oor;
      dec_next.seg = tc_seg;
      dec_next.off = 11'(tc_c - TC_EDGE[5'(tc_seg)]);
    end else begin
      dec_next.oor = cj_oor;
      dec_next.seg = cj_seg;
      dec_next.off = 11'(cj_q - CJ_EDGE[cj_seg]);
    end
  end

  assign up_stall = valid & down_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!up_stall) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!up_stall) begin
      dec <= dec_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/tcl_numer.sv
`default_nettype none
module tcl_numer #(
  parameter int FRAC_BITS = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire tcl_pkg::dec_t                 dec,
  input  wire logic                          down_stall,
  output logic                               up_stall,
  output logic                               valid,
  output logic [((17 + FRAC_BITS > 19) ? 17 + FRAC_BITS : 19)-1:0] num,
  output logic [((17 + FRAC_BITS > 19) ? 17 + FRAC_BITS : 19)+5:0] recip,
  output tcl_pkg::num_ctl_t                  ctl
);
  import tcl_pkg::*;

  localparam int NW = (17 + FRAC_BITS > 19) ? 17 + FRAC_BITS : 19;
  localparam int RS = NW + 11;
  localparam int MW = NW + 6;

  logic [MW-1:0] tc_recip [TC_SEGS];
  logic [MW-1:0] cj_recip [CJ_SEGS];

  for (genvar g = 0; g < TC_SEGS; g++) begin : g_tc_recip
    localparam logic [63:0] D = 64'(TC_DIV[g]);
    localparam logic [63:0] R = ((64'd1 << RS) + D - 64'd1) / D;
    assign tc_recip[g] = MW'(R);
  end

  for (genvar g = 0; g < CJ_SEGS; g++) begin : g_cj_recip
    localparam logic [63:0] D = 64'(CJ_SPAN[g]);
    localparam logic [63:0] R = ((64'd1 << RS) + D - 64'd1) / D;
    assign cj_recip[g] = MW'(R);
  end

  logic [18:0] cj_prod;
  logic [13:0] tc_dtoff;
  logic [16:0] tc_num;
  logic [NW-1:0] num_next;
  logic [MW-1:0] recip_next;
  num_ctl_t      ctl_next;

  always_comb begin
    cj_prod    = '0;
    tc_dtoff   = '0;
    tc_num     = '0;
    ctl_next.op   = dec.op;
    ctl_next.oor  = dec.oor;
    ctl_next.base = '0;
    if (dec.op) begin
      tc_dtoff   = 14'(TC_DT[dec.seg]) * 14'(dec.off[7:0]);
      tc_num     = TC_T0DIV[dec.seg] + 17'(tc_dtoff);
      num_next   = NW'(tc_num) << FRAC_BITS;
      recip_next = tc_recip[dec.seg];
    end else if (dec.seg < seg_t'(CJ_SEGS)) begin
      cj_prod       = 19'(CJ_RISE[dec.seg]) * 19'(dec.off);
      num_next      = NW'(cj_prod);
      recip_next    = cj_recip[dec.seg];
      ctl_next.base = CJ_BASE[dec.seg];
    end else begin
      num_next   = '0;
      recip_next = '0;
    end
  end

  assign up_stall = valid & down_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!up_stall) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!up_stall) begin
      num   <= num_next;
      recip <= recip_next;
      ctl   <= ctl_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/tcl_div.sv
`default_nettype none
module tcl_div #(
  parameter int FRAC_BITS = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire logic [((17 + FRAC_BITS > 19) ? 17 + FRAC_BITS : 19)-1:0] num,
  input  wire logic [((17 + FRAC_BITS > 19) ? 17 + FRAC_BITS : 19)+5:0] recip,
  input  wire tcl_pkg::num_ctl_t             ctl,
  input  wire logic                          out_stall,
  output logic                               up_stall,
  output logic                               out_valid,
  output logic [9:0]                         comp_code,
  output logic [12:0]                        temp_sixteenths,
  output logic                               out_of_range
);
  import tcl_pkg::*;

  localparam int NW = (17 + FRAC_BITS > 19) ? 17 + FRAC_BITS : 19;
  localparam int RS = NW + 11;
  localparam int MW = NW + 6;
  localparam int QW = 9 + FRAC_BITS;
  localparam int TW = (QW > 13) ? QW : 13;

  logic [NW+MW-1:0] prod;
  logic             mul_valid;
  logic             mul_stall;
  logic [QW-1:0]    quot;
  num_ctl_t         mul_ctl;

  logic [TW-1:0]    quot_ext;
  logic [9:0]       comp_next;
  logic [12:0]      temp_next;

  assign prod      = (NW+MW)'(num) * (NW+MW)'(recip);
  assign up_stall  = mul_valid & mul_stall;
  assign mul_stall = out_valid & out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else if (!up_stall) begin
      mul_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!up_stall) begin
      quot    <= prod[RS +: QW];
      mul_ctl <= ctl;
    end
  end

  always_comb begin
    quot_ext  = TW'(quot);
    comp_next = '0;
    temp_next = '0;
    if (!mul_ctl.oor) begin
      if (mul_ctl.op) begin
        temp_next = (quot_ext > TW'(TEMP_MAX)) ? TEMP_MAX : quot_ext[12:0];
      end else begin
        comp_next = 10'(mul_ctl.base) + 10'(quot[7:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!mul_stall) begin
      out_valid <= mul_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!mul_stall) begin
      comp_code       <= comp_next;
      temp_sixteenths <= temp_next;
      out_of_range    <= mul_ctl.oor;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/thermocouple_table_linearizer.sv
`default_nettype none
// channel   direction  handshake              payload
// in        sink       in_valid / in_stall    op, raw_code
// out       source     out_valid / out_stall  comp_code, temp_sixteenths, out_of_range
//
// Four register stages: segment decode, numerator, reciprocal multiply, result.
// One beat per cycle while out is not stalled.
// Synchronous active-high rst clears every stage valid; data registers hold.
// A stall on out holds each full stage; empty stages keep filling behind it.
module thermocouple_table_linearizer #(
  parameter int FRAC_BITS = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               op,
  input  wire logic signed [15:0] raw_code,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [9:0]              comp_code,
  output logic [12:0]             temp_sixteenths,
  output logic                    out_of_range
);
  import tcl_pkg::*;

  localparam int NW = (17 + FRAC_BITS > 19) ? 17 + FRAC_BITS : 19;
  localparam int MW = NW + 6;

  logic          dec_valid;
  logic          dec_stall;
  dec_t          dec;
  logic          num_valid;
  logic          num_stall;
  logic [NW-1:0] num;
  logic [MW-1:0] recip;
  num_ctl_t      ctl;

  tcl_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .op         (op),
    .raw_code   (raw_code),
    .down_stall (dec_stall),
    .up_stall   (in_stall),
    .valid      (dec_valid),
    .dec        (dec)
  );

  tcl_numer #(.FRAC_BITS(FRAC_BITS)) u_numer (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (dec_valid),
    .dec        (dec),
    .down_stall (num_stall),
    .up_stall   (dec_stall),
    .valid      (num_valid),
    .num        (num),
    .recip      (recip),
    .ctl        (ctl)
  );

  tcl_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (num_valid),
    .num             (num),
    .recip           (recip),
    .ctl             (ctl),
    .out_stall       (out_stall),
    .up_stall        (num_stall),
    .out_valid       (out_valid),
    .comp_code       (comp_code),
    .temp_sixteenths (temp_sixteenths),
    .out_of_range    (out_of_range)
  );

endmodule
`default_nettype wire
